/* src/phwt_pkg.sv */
// Shared types and constants for the path health window tracker.
package phwt_pkg;

    localparam int SLOT_W  = 6;
    localparam int PATH_W  = 3;
    localparam int COST_W  = 24;
    localparam int STAMP_W = 48;
    localparam int CFG_W   = 32;

    localparam logic [CFG_W-1:0] DEST_EXPIRE_RESET = 32'd600000;
    localparam logic [CFG_W-1:0] PATH_EXPIRE_RESET = 32'd86400000;

    localparam logic REG_DEST_EXPIRE = 1'b0;
    localparam logic REG_PATH_EXPIRE = 1'b1;

    localparam logic [1:0] VERDICT_NONE    = 2'd0;
    localparam logic [1:0] VERDICT_FORBID  = 2'd1;
    localparam logic [1:0] VERDICT_RECOVER = 2'd2;

    typedef struct packed {
        logic [SLOT_W-1:0]  dest_slot;
        logic [PATH_W-1:0]  path_index;
        logic               succeeded;
        logic [COST_W-1:0]  first_byte_cost;
        logic [STAMP_W-1:0] now_ms;
    } phwt_in_t;

    typedef struct packed {
        logic [3:0]        dest_success_count;
        logic [3:0]        dest_failed_count;
        logic [COST_W-1:0] dest_avg_cost;
        logic [3:0]        path_success_count;
        logic [3:0]        path_failed_count;
        logic [COST_W-1:0] path_avg_cost;
        logic [1:0]        verdict;
    } phwt_out_t;

    typedef struct packed {
        logic take;
        logic append;
        logic scan;
        logic div_start;
        logic load_out;
    } phwt_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic div_done;
        logic out_busy;
    } phwt_status_t;

endpackage

/* src/path_health_window_tracker_unit.sv */
// Top level: configuration registers, controller and datapath.
// From item accept to result valid the controller steps through append, scan, drain,
// divider start and wait, and load. A new item is accepted only after the result of the
// last one was loaded into the result register; a stalled result delays this.
// Reset: fill counts read as empty, expiry registers return to 600000 and 86400000 ms.
// Ring memories hold no reset; an entry is counted only after it was written.
module path_health_window_tracker_unit #(
    parameter int DEST_WINDOW  = 8,
    parameter int PATH_WINDOW  = 8,
    parameter int DEST_ENTRIES = 64,
    parameter int PATH_COUNT   = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  phwt_pkg::phwt_in_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output phwt_pkg::phwt_out_t   out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import phwt_pkg::*;

    logic [CFG_W-1:0] dest_expire_reg;
    logic [CFG_W-1:0] path_expire_reg;
    phwt_cmd_t        cmd;
    phwt_status_t     status;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PATH_EXPIRE) ? path_expire_reg : dest_expire_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_expire_reg <= DEST_EXPIRE_RESET;
            path_expire_reg <= PATH_EXPIRE_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_DEST_EXPIRE)
            begin
                dest_expire_reg <= pwdata;
            end
            else
            begin
                path_expire_reg <= pwdata;
            end
        end
    end

    phwt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    phwt_dp #(
        .DEST_WINDOW  (DEST_WINDOW),
        .PATH_WINDOW  (PATH_WINDOW),
        .DEST_ENTRIES (DEST_ENTRIES),
        .PATH_COUNT   (PATH_COUNT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_data     (in_data),
        .dest_expire (dest_expire_reg),
        .path_expire (path_expire_reg),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

/* src/phwt_div.sv */
// Restoring divider, one quotient bit per cycle.
module phwt_div #(
    parameter int NW = 30,
    parameter int DW = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          busy,
    output logic [NW-1:0] quotient
);
    localparam int CW = $clog2(NW + 1);

    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] dvs_reg;
    logic [DW-1:0] rem_reg;
    logic [NW-1:0] quo_reg;
    logic [DW:0]   trial;
    logic          fits;

    assign trial    = {rem_reg, quo_reg[NW-1]};
    assign fits     = trial >= {1'b0, dvs_reg};
    assign busy     = cnt_reg != '0;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CW'(NW);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy)
        begin
            rem_reg <= fits ? DW'(trial - {1'b0, dvs_reg}) : trial[DW-1:0];
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end

endmodule

/* src/phwt_ctrl.sv */
// Controller state machine for the path health window tracker.
module phwt_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output phwt_pkg::phwt_cmd_t    cmd,
    input  phwt_pkg::phwt_status_t status
);
    import phwt_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_APPEND    = 7'b0000010,
        S_SCAN      = 7'b0000100,
        S_DRAIN     = 7'b0001000,
        S_DIV_START = 7'b0010000,
        S_DIV_WAIT  = 7'b0100000,
        S_OUT       = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_APPEND;
                end
            end
            S_APPEND:
            begin
                cmd.append = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DIV_START;
            end
            S_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* src/phwt_dp.sv */
// Datapath: ring memories, fill counters, window tallies, dividers and result register.
module phwt_dp #(
    parameter int DEST_WINDOW  = 8,
    parameter int PATH_WINDOW  = 8,
    parameter int DEST_ENTRIES = 64,
    parameter int PATH_COUNT   = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  phwt_pkg::phwt_in_t     in_data,
    input  logic [31:0]           dest_expire,
    input  logic [31:0]           path_expire,
    input  phwt_pkg::phwt_cmd_t    cmd,
    output phwt_pkg::phwt_status_t status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output phwt_pkg::phwt_out_t    out_data
);
    import phwt_pkg::*;

    localparam int SLOTS = (DEST_ENTRIES < 64) ? DEST_ENTRIES : 64;
    localparam int SI_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PI_W  = (PATH_COUNT > 1) ? $clog2(PATH_COUNT) : 1;
    localparam int DPW   = (DEST_WINDOW > 1) ? $clog2(DEST_WINDOW) : 1;
    localparam int PPW   = (PATH_WINDOW > 1) ? $clog2(PATH_WINDOW) : 1;
    localparam int MAXW  = (DEST_WINDOW > PATH_WINDOW) ? DEST_WINDOW : PATH_WINDOW;
    localparam int IW    = (MAXW > 1) ? $clog2(MAXW) : 1;
    localparam int DTW   = $clog2(DEST_WINDOW + 1);
    localparam int PTW   = $clog2(PATH_WINDOW + 1);
    localparam int DSW   = COST_W + DTW;
    localparam int PSW   = COST_W + PTW;
    localparam int DDEP  = SLOTS * DEST_WINDOW;
    localparam int PDEP  = SLOTS * PATH_COUNT * PATH_WINDOW;
    localparam int DAW   = (DDEP > 1) ? $clog2(DDEP) : 1;
    localparam int PAW   = (PDEP > 1) ? $clog2(PDEP) : 1;
    localparam int REC_W = STAMP_W + 1 + COST_W;

    typedef struct packed {
        logic           dest_full;
        logic [DPW-1:0] dest_ptr;
        logic [PATH_COUNT-1:0][PPW:0] path_pos;
    } row_t;

    logic [SI_W-1:0] slot_tab [64];
    logic [PI_W-1:0] path_tab [8];

    genvar g;
    generate
        for (g = 0; g < 64; g++)
        begin : g_slot
            assign slot_tab[g] = SI_W'(g % DEST_ENTRIES);
        end
        for (g = 0; g < 8; g++)
        begin : g_path
            assign path_tab[g] = PI_W'(g % PATH_COUNT);
        end
    endgenerate

    row_t             cnt_mem [SLOTS];
    logic [SLOTS-1:0] cnt_vld_reg;
    logic [REC_W-1:0] d_mem [DDEP];
    logic [REC_W-1:0] p_mem [PDEP];

    phwt_in_t        item_reg;
    logic [SI_W-1:0] slot_reg;
    logic [PI_W-1:0] path_reg;
    row_t            cnt_rd_reg;
    logic            cnt_hit_reg;
    row_t            row_cur;
    row_t            row_next;
    row_t            row_reg;
    logic [DPW:0]    d_fill_reg;
    logic [PPW:0]    p_fill_reg;
    logic [DAW-1:0]  d_base;
    logic [PAW-1:0]  p_base;
    logic [PPW:0]    p_pos;
    logic [DPW-1:0]  d_ptr_next;
    logic            d_full_next;
    logic [PPW-1:0]  p_ptr_next;
    logic            p_full_next;

    logic [IW-1:0]    scan_idx_reg;
    logic [IW-1:0]    rd_idx_reg;
    logic             rd_vld_reg;
    logic [REC_W-1:0] d_rd_reg;
    logic [REC_W-1:0] p_rd_reg;
    logic [DAW-1:0]   d_rd_addr;
    logic [PAW-1:0]   p_rd_addr;
    logic [STAMP_W-1:0] d_age;
    logic [STAMP_W-1:0] p_age;
    logic             d_take;
    logic             p_take;

    logic [DTW-1:0] d_ok_reg;
    logic [DTW-1:0] d_bad_reg;
    logic [DSW-1:0] d_sum_reg;
    logic [PTW-1:0] p_ok_reg;
    logic [PTW-1:0] p_bad_reg;
    logic [PSW-1:0] p_sum_reg;

    logic           dest_all_bad;
    logic [1:0]     verdict_next;
    logic [1:0]     verdict_reg;
    row_t           row_final;
    logic           d_div_busy;
    logic           p_div_busy;
    logic [DSW-1:0] d_quo;
    logic [PSW-1:0] p_quo;

    logic      out_valid_reg;
    phwt_out_t out_data_reg;
    phwt_out_t out_next;

    function automatic logic [3:0] sat4(input logic [7:0] v);
        return (v > 8'd15) ? 4'd15 : v[3:0];
    endfunction

    assign row_cur     = cnt_hit_reg ? cnt_rd_reg : '0;
    assign p_pos       = row_cur.path_pos[path_reg];
    assign d_base      = DAW'(slot_reg * DEST_WINDOW);
    assign p_base      = PAW'((slot_reg * PATH_COUNT + path_reg) * PATH_WINDOW);
    assign d_full_next = row_cur.dest_full || (row_cur.dest_ptr == DPW'(DEST_WINDOW - 1));
    assign d_ptr_next  = (row_cur.dest_ptr == DPW'(DEST_WINDOW - 1)) ? '0
                         : row_cur.dest_ptr + 1'b1;
    assign p_full_next = p_pos[PPW] || (p_pos[PPW-1:0] == PPW'(PATH_WINDOW - 1));
    assign p_ptr_next  = (p_pos[PPW-1:0] == PPW'(PATH_WINDOW - 1)) ? '0
                         : p_pos[PPW-1:0] + 1'b1;

    always_comb
    begin
        row_next                    = row_cur;
        row_next.dest_full          = d_full_next;
        row_next.dest_ptr           = d_ptr_next;
        row_next.path_pos[path_reg] = {p_full_next, p_ptr_next};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            item_reg   <= in_data;
            slot_reg   <= slot_tab[in_data.dest_slot];
            path_reg   <= path_tab[in_data.path_index];
            cnt_rd_reg <= cnt_mem[slot_tab[in_data.dest_slot]];
        end
        if (cmd.append)
        begin
            row_reg    <= row_next;
            d_fill_reg <= d_full_next ? (DPW+1)'(DEST_WINDOW) : {1'b0, d_ptr_next};
            p_fill_reg <= p_full_next ? (PPW+1)'(PATH_WINDOW) : {1'b0, p_ptr_next};
        end
        if (cmd.div_start)
        begin
            cnt_mem[slot_reg] <= row_final;
            verdict_reg       <= verdict_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_vld_reg <= '0;
            cnt_hit_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take)
            begin
                cnt_hit_reg <= cnt_vld_reg[slot_tab[in_data.dest_slot]];
            end
            if (cmd.div_start)
            begin
                cnt_vld_reg[slot_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            d_mem[d_base + DAW'(row_cur.dest_ptr)] <=
                {item_reg.now_ms, item_reg.succeeded,
                 item_reg.succeeded ? item_reg.first_byte_cost : {COST_W{1'b0}}};
            p_mem[p_base + PAW'(p_pos[PPW-1:0])] <=
                {item_reg.now_ms, item_reg.succeeded,
                 item_reg.succeeded ? item_reg.first_byte_cost : {COST_W{1'b0}}};
        end
        if (cmd.scan)
        begin
            d_rd_reg <= d_mem[d_rd_addr];
            p_rd_reg <= p_mem[p_rd_addr];
        end
    end

    assign d_rd_addr = d_base + ((scan_idx_reg < DEST_WINDOW) ? DAW'(scan_idx_reg) : '0);
    assign p_rd_addr = p_base + ((scan_idx_reg < PATH_WINDOW) ? PAW'(scan_idx_reg) : '0);
    assign status.scan_last = scan_idx_reg == IW'(MAXW - 1);

    assign d_age  = item_reg.now_ms - d_rd_reg[REC_W-1 -: STAMP_W];
    assign p_age  = item_reg.now_ms - p_rd_reg[REC_W-1 -: STAMP_W];
    assign d_take = rd_vld_reg && ((DPW+1)'(rd_idx_reg) < d_fill_reg)
                    && (d_age <= {16'd0, dest_expire}) && (IW'(MAXW - 1) >= rd_idx_reg)
                    && (rd_idx_reg < DEST_WINDOW);
    assign p_take = rd_vld_reg && ((PPW+1)'(rd_idx_reg) < p_fill_reg)
                    && (p_age <= {16'd0, path_expire}) && (rd_idx_reg < PATH_WINDOW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            rd_vld_reg   <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.scan;
            if (cmd.append)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.scan && !status.scan_last)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan)
        begin
            rd_idx_reg <= scan_idx_reg;
        end
        if (cmd.append)
        begin
            d_ok_reg  <= '0;
            d_bad_reg <= '0;
            d_sum_reg <= '0;
            p_ok_reg  <= '0;
            p_bad_reg <= '0;
            p_sum_reg <= '0;
        end
        else
        begin
            if (d_take)
            begin
                if (d_rd_reg[COST_W])
                begin
                    d_ok_reg  <= d_ok_reg + 1'b1;
                    d_sum_reg <= d_sum_reg + DSW'(d_rd_reg[COST_W-1:0]);
                end
                else
                begin
                    d_bad_reg <= d_bad_reg + 1'b1;
                end
            end
            if (p_take)
            begin
                if (p_rd_reg[COST_W])
                begin
                    p_ok_reg  <= p_ok_reg + 1'b1;
                    p_sum_reg <= p_sum_reg + PSW'(p_rd_reg[COST_W-1:0]);
                end
                else
                begin
                    p_bad_reg <= p_bad_reg + 1'b1;
                end
            end
        end
    end

    assign dest_all_bad = d_bad_reg == DTW'(DEST_WINDOW);

    always_comb
    begin
        row_final = row_reg;
        if (item_reg.succeeded)
        begin
            verdict_next = dest_all_bad ? VERDICT_NONE : VERDICT_RECOVER;
        end
        else if (dest_all_bad)
        begin
            verdict_next       = VERDICT_FORBID;
            row_final.path_pos = '0;
        end
        else
        begin
            verdict_next = VERDICT_NONE;
        end
    end

    phwt_div #(.NW(DSW), .DW(DTW)) u_dest_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (d_sum_reg),
        .divisor  (d_ok_reg),
        .busy     (d_div_busy),
        .quotient (d_quo)
    );

    phwt_div #(.NW(PSW), .DW(PTW)) u_path_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (p_sum_reg),
        .divisor  (p_ok_reg),
        .busy     (p_div_busy),
        .quotient (p_quo)
    );

    assign status.div_done = !d_div_busy && !p_div_busy;
    assign status.out_busy = out_valid_reg && !out_ready;

    always_comb
    begin
        out_next.dest_success_count = sat4(8'(d_ok_reg));
        out_next.dest_failed_count  = sat4(8'(d_bad_reg));
        out_next.dest_avg_cost      = (d_ok_reg == '0) ? '0 : d_quo[COST_W-1:0];
        out_next.path_success_count = sat4(8'(p_ok_reg));
        out_next.path_failed_count  = sat4(8'(p_bad_reg));
        out_next.path_avg_cost      = (p_ok_reg == '0) ? '0 : p_quo[COST_W-1:0];
        out_next.verdict            = verdict_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (out_next.verdict != 2'd3))
        else $error("illegal verdict code");

    a_forbid_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && out_next.verdict == VERDICT_FORBID) |-> !item_reg.succeeded)
        else $error("forbid raised by a success");

    a_dest_window: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> ((8'(d_ok_reg) + 8'(d_bad_reg)) <= 8'(DEST_WINDOW)))
        else $error("destination tally exceeds window");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(out_valid_reg && !out_ready))
        else $error("result loaded over a pending item");

endmodule
